>>> rtl/core/rsi_pkg.sv
// Shared types, constants and helpers for the radix string-to-integer unit.
// Used by rsi_front, rsi_queue, rsi_back and the top level; no dependencies.
package rsi_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CONS_WIDTH  = 16;
  localparam int DEPTH       = 2;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] NO_DIGIT  = 6'd36;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [2:0] KIND_U8  = 3'd0;
  localparam logic [2:0] KIND_I8  = 3'd1;
  localparam logic [2:0] KIND_U16 = 3'd2;
  localparam logic [2:0] KIND_I16 = 3'd3;
  localparam logic [2:0] KIND_U32 = 3'd4;
  localparam logic [2:0] KIND_I32 = 3'd5;
  localparam logic [2:0] KIND_U64 = 3'd6;
  localparam logic [2:0] KIND_I64 = 3'd7;

  localparam logic [7:0] REG_RADIX = 8'd0;
  localparam logic [7:0] REG_KIND  = 8'd1;

  // One queued command for the back end
  typedef struct packed {
    logic                   mac;
    logic [5:0]             digit;
    logic [5:0]             radix;
    logic                   last;
    logic                   neg;
    logic [CONS_WIDTH-1:0]  consumed;
    logic                   err;
    logic [2:0]             kind;
  } rsi_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rsi_qstat_t;

  // Map a character to its digit value, NO_DIGIT when it is none
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(NO_DIGIT);
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end
    return d[5:0];
  endfunction

  // Saturate the running count to the result field width
  function automatic logic [CONS_WIDTH-1:0] sat_count(input logic [COUNT_WIDTH-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    if (w > 32'(CONS_WIDTH == 32 ? 32'hFFFF_FFFF : (32'd1 << CONS_WIDTH) - 32'd1)) begin
      return '1;
    end
    return w[CONS_WIDTH-1:0];
  endfunction

  // Wrap to the selected integer type, sign- or zero-extended to 64 bits
  function automatic logic [63:0] wrap_kind(input logic [63:0] v, input logic [2:0] kind);
    logic [63:0] r;
    case (kind)
      KIND_U8:  r = {56'd0, v[7:0]};
      KIND_I8:  r = {{56{v[7]}}, v[7:0]};
      KIND_U16: r = {48'd0, v[15:0]};
      KIND_I16: r = {{48{v[15]}}, v[15:0]};
      KIND_U32: r = {32'd0, v[31:0]};
      KIND_I32: r = {{32{v[31]}}, v[31:0]};
      default:  r = v;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/rsi_front.sv
// Front end: accepts characters, tracks sign, phase and count, issues commands.
// Depends on rsi_pkg.
module rsi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          ch,
  input  logic                last,
  input  logic [5:0]          radix,
  input  logic [2:0]          kind,
  input  rsi_pkg::rsi_qstat_t qstat,
  output logic                push,
  output rsi_pkg::rsi_cmd_t   cmd
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ACC   = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;
  localparam logic [1:0] PH_BAD   = 2'd3;

  logic [1:0]                      phase_r, phase_nxt;
  logic                            neg_r, neg_nxt;
  logic [rsi_pkg::COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                            accept, mac, radix_ok, is_sign;
  logic [5:0]                      dig;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign radix_ok = (radix >= rsi_pkg::RADIX_MIN) && (radix <= rsi_pkg::RADIX_MAX);
  assign is_sign  = (ch == rsi_pkg::CH_PLUS) || (ch == rsi_pkg::CH_MINUS);
  assign dig      = rsi_pkg::digit_of(ch);

  // Classify the character against the current phase
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    mac       = 1'b0;
    if (phase_r == PH_START || phase_r == PH_ACC) begin
      if (!radix_ok) begin
        phase_nxt = PH_BAD;
      end else if (phase_r == PH_START && is_sign) begin
        phase_nxt = PH_ACC;
        neg_nxt   = (ch == rsi_pkg::CH_MINUS);
        if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
      end else if (dig < radix) begin
        phase_nxt = PH_ACC;
        mac       = 1'b1;
        if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
      end else begin
        phase_nxt = PH_STOP;
      end
    end
  end

  // Build the command for the back end
  always_comb begin
    cmd.mac      = mac;
    cmd.digit    = dig;
    cmd.radix    = radix;
    cmd.last     = last;
    cmd.neg      = neg_nxt;
    cmd.err      = (phase_nxt == PH_BAD);
    cmd.consumed = (phase_nxt == PH_BAD) ? '0 : rsi_pkg::sat_count(cnt_nxt);
    cmd.kind     = kind;
  end

  assign push = accept && (mac || last);

  // Advance string state, clear after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (accept) begin
      if (last) begin
        phase_r <= PH_START;
        neg_r   <= 1'b0;
        cnt_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule

>>> rtl/core/rsi_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on rsi_pkg.
module rsi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rsi_pkg::rsi_cmd_t   wr_cmd,
  input  logic                pop,
  output rsi_pkg::rsi_cmd_t   rd_cmd,
  output rsi_pkg::rsi_qstat_t qstat
);

  localparam int PW = $clog2(rsi_pkg::DEPTH);

  rsi_pkg::rsi_cmd_t mem_r [rsi_pkg::DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == (PW+1)'(rsi_pkg::DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign rd_cmd      = mem_r[rp_r];

  // Step pointers, wrapping at the depth
  always_comb begin
    wp_nxt  = (wp_r == PW'(rsi_pkg::DEPTH - 1)) ? '0 : wp_r + 1'b1;
    rp_nxt  = (rp_r == PW'(rsi_pkg::DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_nxt;
      if (pop)  rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_cmd;
  end

endmodule

>>> rtl/core/rsi_back.sv
// Back end: multiply-accumulate per digit, finish and register the result.
// Depends on rsi_pkg.
module rsi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rsi_pkg::rsi_cmd_t   cmd,
  input  rsi_pkg::rsi_qstat_t qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         value_bits,
  output logic [rsi_pkg::CONS_WIDTH-1:0] consumed,
  output logic                status
);

  logic [63:0]                    acc_r, acc_m, signed_v;
  logic                           ov_r, ov_nxt;
  logic [63:0]                    val_r;
  logic [rsi_pkg::CONS_WIDTH-1:0] cons_r;
  logic                           st_r;

  // Drain non-final words freely; final words need the output slot
  assign pop = !qstat.empty && (!cmd.last || !ov_r || out_ready);

  always_comb begin
    acc_m    = cmd.mac ? 64'(acc_r * 64'(cmd.radix)) + 64'(cmd.digit) : acc_r;
    signed_v = cmd.neg ? 64'd0 - acc_m : acc_m;
    ov_nxt   = (ov_r && !out_ready) || (pop && cmd.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (pop) acc_r <= cmd.last ? 64'd0 : acc_m;
    end
  end

  // Load the output register on a final word
  always_ff @(posedge clk) begin
    if (pop && cmd.last) begin
      val_r  <= cmd.err ? 64'd0 : rsi_pkg::wrap_kind(signed_v, cmd.kind);
      cons_r <= cmd.consumed;
      st_r   <= cmd.err;
    end
  end

  assign out_valid  = ov_r;
  assign value_bits = val_r;
  assign consumed   = cons_r;
  assign status     = st_r;

endmodule

>>> rtl/core/radix_string_to_integer_unit.sv
// Top level of the radix string-to-integer unit: config registers and wiring.
// Depends on rsi_pkg, rsi_front, rsi_queue and rsi_back.
//
// Usage:
//   in_*  : one character per word, in_tdata = ch, in_tlast marks the last one.
//   out_* : one result word per string, sent on the word carrying in_tlast.
//   cfg_* : register writes, index 0 = radix (6 bits), 1 = result kind (3 bits);
//           cfg_ready is always high. Write only while no string is in flight.
// Throughput: one character per cycle while the queue is not full. The back end's
//   64-bit multiply-accumulate by the radix is combinational, registered per digit.
// Result path: the last character's command is written into the queue, and the
//   back end then pops it into the output register once that register is free.
// Reset clears string state, the queue and the output valid flag; radix returns
//   to 10 and the kind to i32.
// A stalled receiver holds the output register; the back end keeps draining
//   digit words, and the front end stops only when the two-word queue fills.
module radix_string_to_integer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [63:0] value_bits, [79:64] consumed, [80] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [5:0]                     radix_r;
  logic [2:0]                     kind_r;
  logic                           push, pop;
  rsi_pkg::rsi_cmd_t              wr_cmd, rd_cmd;
  rsi_pkg::rsi_qstat_t            qstat;
  logic [63:0]                    value_bits;
  logic [rsi_pkg::CONS_WIDTH-1:0] consumed;
  logic                           status;

  assign cfg_ready = 1'b1;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= 6'd10;
      kind_r  <= rsi_pkg::KIND_I32;
    end else if (cfg_valid) begin
      case (cfg_index)
        rsi_pkg::REG_RADIX: radix_r <= cfg_data[5:0];
        rsi_pkg::REG_KIND:  kind_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .ch       (in_tdata),
    .last     (in_tlast),
    .radix    (radix_r),
    .kind     (kind_r),
    .qstat    (qstat),
    .push     (push),
    .cmd      (wr_cmd)
  );

  rsi_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .qstat  (qstat)
  );

  rsi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (rd_cmd),
    .qstat      (qstat),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .value_bits (value_bits),
    .consumed   (consumed),
    .status     (status)
  );

  assign out_tdata = {7'd0, status, consumed, value_bits};

  // Queue can never be full and empty at once
  a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty together");

  // Invalid-radix results carry zero value and zero count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status |-> (value_bits == 64'd0) && (consumed == '0))
    else $error("error result with nonzero payload");

  // Last character into an idle pipe yields a result via the queue and output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && qstat.empty && !out_tvalid |-> ##2 out_tvalid)
    else $error("result missing after last character");

endmodule
